// ===== hdl/asrb_pkg.sv =====
// Package for the audio sample ring buffer.
// Holds the shared field widths, the default sizes and the command codes.
// It has no dependencies.
package asrb_pkg;

  localparam int unsigned DepthDefault    = 4096;
  localparam int unsigned MaxBlockDefault = 64;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned LenW    = 7;
  localparam int unsigned CountW  = 32;
  localparam int unsigned CmdW    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

endpackage

// ===== hdl/asrb_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// The read data appears in the cycle after the read enable. It has no dependencies.
module asrb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/audio_sample_ring_buffer.sv =====
// Audio sample ring buffer: an overwriting circular FIFO of signed 16-bit samples.
// An add, a reset or a refused get keeps busy low, so such commands may be issued
// every cycle; their single result is strobed in the cycle after the command is
// accepted. A served get of N samples holds busy high while the read sequencer
// reads one sample per cycle from the sample RAM's read port; its results are
// strobed in consecutive cycles, each sample passing the S_GET state and the RAM
// read register, and busy drops so that the next command may be accepted in the
// cycle that carries the final sample. The receiver cannot stall results.
// Writing buffer_size clears the pointers like a reset command. The sample store
// needs no clearing after reset, so the block is ready at once.
// Depends on asrb_pkg and asrb_ram.
module audio_sample_ring_buffer
  import asrb_pkg::*;
#(
  parameter int unsigned DEPTH     = DepthDefault,
  parameter int unsigned MAX_BLOCK = MaxBlockDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [CmdW-1:0]           cmd_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [LenW-1:0]           block_length_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [SizeW-1:0]          cfg_data_i,
  output logic                      strobe_o,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic [CountW-1:0]         timestamp_o,
  output logic                      served_o,
  output logic                      last_o,
  output logic                      overwrote_now_o,
  output logic [CountW-1:0]         overwrite_total_o,
  output logic [CountW-1:0]         skipped_total_o,
  output logic [SizeW-1:0]          fill_level_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_GET
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      wi_q, wi_d;
  logic [AW-1:0]      ri_q, ri_d;
  logic [CntW-1:0]    held_q, held_d;
  logic [CntW-1:0]    size_q, size_d;
  logic [CountW-1:0]  rc_q, rc_d;
  logic [CountW-1:0]  ovw_cnt_q, ovw_cnt_d;
  logic [CountW-1:0]  skip_q, skip_d;
  logic [CountW-1:0]  ts_q, ts_d;
  logic [LenW-1:0]    rem_q, rem_d;
  logic               res_valid_q, res_valid_d;
  logic               res_ovw_q, res_ovw_d;
  logic               rd_valid_q, rd_valid_d;
  logic               rd_last_q, rd_last_d;

  logic               accept;
  logic               cfg_fire;
  logic               ovw;
  logic [AW-1:0]      wi_next;
  logic               ram_we;
  logic               ram_re;
  logic [SampleW-1:0] ram_rdata;
  cmd_e               cmd;

  function automatic logic [AW-1:0] next_idx(logic [AW-1:0] idx, logic [CntW-1:0] sz);
    logic [CntW-1:0] inc;
    inc = CntW'(idx) + CntW'(1);
    return (inc >= sz) ? '0 : AW'(inc);
  endfunction

  function automatic logic [CntW-1:0] clamp_size(logic [SizeW-1:0] v);
    logic [CntW-1:0] res;
    if (v == '0) begin
      res = CntW'(1);
    end else if (32'(v) > 32'(DEPTH)) begin
      res = CntW'(DEPTH);
    end else begin
      res = CntW'(v);
    end
    return res;
  endfunction

  assign busy        = (state_q != S_IDLE);
  // A command offered in the same cycle goes first, so the write waits for it.
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign accept      = start && !busy;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign cmd         = cmd_e'(cmd_i);
  assign ovw         = (held_q != '0) && (ri_q == wi_q);
  assign wi_next     = next_idx(wi_q, size_q);

  always_comb begin
    state_d     = state_q;
    wi_d        = wi_q;
    ri_d        = ri_q;
    held_d      = held_q;
    size_d      = size_q;
    rc_d        = rc_q;
    ovw_cnt_d   = ovw_cnt_q;
    skip_d      = skip_q;
    ts_d        = ts_q;
    rem_d       = rem_q;
    res_valid_d = 1'b0;
    res_ovw_d   = 1'b0;
    rd_valid_d  = 1'b0;
    rd_last_d   = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (state_q == S_GET) begin
      // Stream one sample per cycle; the data lands in the next cycle.
      ram_re     = 1'b1;
      ri_d       = next_idx(ri_q, size_q);
      rem_d      = rem_q - LenW'(1);
      rd_valid_d = 1'b1;
      rd_last_d  = (rem_q == LenW'(1));
      if (rem_q == LenW'(1)) begin
        state_d = S_IDLE;
      end
    end else if (cfg_fire) begin
      size_d    = clamp_size(cfg_data_i);
      skip_d    = skip_q + CountW'(held_q);
      held_d    = '0;
      wi_d      = '0;
      ri_d      = '0;
      rc_d      = '0;
      ovw_cnt_d = '0;
    end else if (accept) begin
      case (cmd)
        CMD_ADD: begin
          ram_we      = 1'b1;
          held_d      = (held_q < size_q) ? held_q + CntW'(1) : held_q;
          wi_d        = wi_next;
          res_valid_d = 1'b1;
          res_ovw_d   = ovw;
          if (ovw) begin
            // The oldest unread sample is gone, so the read side follows.
            ri_d      = wi_next;
            ovw_cnt_d = ovw_cnt_q + CountW'(1);
            skip_d    = skip_q + CountW'(1);
          end
        end
        CMD_GET: begin
          if (block_length_i == '0 || 32'(block_length_i) > 32'(MAX_BLOCK) ||
              32'(held_q) < 32'(block_length_i)) begin
            res_valid_d = 1'b1;
          end else begin
            state_d = S_GET;
            rem_d   = block_length_i;
            ts_d    = rc_q;
            rc_d    = rc_q + CountW'(block_length_i);
            held_d  = held_q - CntW'(block_length_i);
          end
        end
        CMD_RESET: begin
          skip_d      = skip_q + CountW'(held_q);
          held_d      = '0;
          wi_d        = '0;
          ri_d        = '0;
          rc_d        = '0;
          ovw_cnt_d   = '0;
          res_valid_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wi_q        <= '0;
      ri_q        <= '0;
      held_q      <= '0;
      size_q      <= clamp_size(SizeW'(DepthDefault));
      rc_q        <= '0;
      ovw_cnt_q   <= '0;
      skip_q      <= '0;
      rem_q       <= '0;
      res_valid_q <= 1'b0;
      res_ovw_q   <= 1'b0;
      rd_valid_q  <= 1'b0;
      rd_last_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      wi_q        <= wi_d;
      ri_q        <= ri_d;
      held_q      <= held_d;
      size_q      <= size_d;
      rc_q        <= rc_d;
      ovw_cnt_q   <= ovw_cnt_d;
      skip_q      <= skip_d;
      rem_q       <= rem_d;
      res_valid_q <= res_valid_d;
      res_ovw_q   <= res_ovw_d;
      rd_valid_q  <= rd_valid_d;
      rd_last_q   <= rd_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ts_q <= ts_d;
  end

  asrb_ram #(
    .Width(SampleW),
    .Depth(DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi_q),
    .wdata_i (sample_i),
    .re_i    (ram_re),
    .raddr_i (ri_q),
    .rdata_o (ram_rdata)
  );

  assign strobe_o          = res_valid_q || rd_valid_q;
  assign sample_out_o      = rd_valid_q ? ram_rdata : '0;
  assign timestamp_o       = rd_valid_q ? ts_q : '0;
  assign served_o          = rd_valid_q;
  assign last_o            = res_valid_q || (rd_valid_q && rd_last_q);
  assign overwrote_now_o   = res_valid_q && res_ovw_q;
  assign overwrite_total_o = ovw_cnt_q;
  assign skipped_total_o   = skip_q;
  assign fill_level_o      = SizeW'(held_q);

  // A single-item result and a streamed sample never share a cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid_q && rd_valid_q))
    else $error("single result collides with streamed sample");

  // The fill level never exceeds the configured size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= size_q)
    else $error("fill level above buffer size");

  // Both pointers stay inside the slots in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CntW'(wi_q) < size_q) && (CntW'(ri_q) < size_q))
    else $error("pointer outside buffer size");

  // The final streamed sample arrives after the read sequencer has gone idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && rd_last_q) |-> (state_q == S_IDLE))
    else $error("last sample while still reading");

endmodule

// ===== bench/tb_audio_sample_ring_buffer.sv =====
// Self-checking testbench for the audio sample ring buffer.
// A command queue feeds a clocked driver; a clocked monitor predicts and checks every result.
// Depends on asrb_pkg and the audio_sample_ring_buffer RTL.
module tb_audio_sample_ring_buffer import asrb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned MaxReports    = 10;
  localparam int unsigned IdxW          = $clog2(DepthDefault);

  typedef struct packed {
    cmd_e                      cmd;
    logic signed [SampleW-1:0] sample;
    logic [LenW-1:0]           len;
  } command_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic [CountW-1:0]         timestamp;
    logic                      served;
    logic                      last;
    logic                      overwrote;
    logic [CountW-1:0]         overwrite_total;
    logic [CountW-1:0]         skipped_total;
    logic [SizeW-1:0]          fill;
  } result_t;

  logic                      clk          = 1'b0;
  logic                      rst_n        = 1'b0;
  logic                      start        = 1'b0;
  logic                      busy;
  logic [CmdW-1:0]           cmd          = CMD_ADD;
  logic signed [SampleW-1:0] sample       = '0;
  logic [LenW-1:0]           block_length = '0;
  logic                      cfg_valid    = 1'b0;
  logic                      cfg_ready;
  logic [SizeW-1:0]          cfg_data     = '0;
  logic                      strobe;
  logic signed [SampleW-1:0] sample_out;
  logic [CountW-1:0]         timestamp;
  logic                      served;
  logic                      last;
  logic                      overwrote_now;
  logic [CountW-1:0]         overwrite_total;
  logic [CountW-1:0]         skipped_total;
  logic [SizeW-1:0]          fill_level;

  // Shadow copy of the ring buffer state.
  logic signed [SampleW-1:0] ring_mem [DepthDefault];
  logic [SizeW-1:0]          wr_ptr          = '0;
  logic [SizeW-1:0]          rd_ptr          = '0;
  logic [SizeW-1:0]          held            = '0;
  logic [SizeW-1:0]          ring_size       = SizeW'(DepthDefault);
  logic [CountW-1:0]         read_count      = '0;
  logic [CountW-1:0]         overwrite_count = '0;
  logic [CountW-1:0]         skip_count      = '0;

  command_t    pending_cmds[$];
  result_t     expected_results[$];
  int unsigned queued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count    = 0;
  int unsigned idle_cycles    = 0;
  int unsigned gap_left       = 0;
  bit          cmd_fire       = 1'b0;
  bit          gaps_on        = 1'b1;

  audio_sample_ring_buffer i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start             (start),
    .busy              (busy),
    .cmd_i             (cmd),
    .sample_i          (sample),
    .block_length_i    (block_length),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data),
    .strobe_o          (strobe),
    .sample_out_o      (sample_out),
    .timestamp_o       (timestamp),
    .served_o          (served),
    .last_o            (last),
    .overwrote_now_o   (overwrote_now),
    .overwrite_total_o (overwrite_total),
    .skipped_total_o   (skipped_total),
    .fill_level_o      (fill_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [SizeW-1:0] clamp_size(logic [SizeW-1:0] v);
    if (v == 0) return SizeW'(1);
    if (v > DepthDefault) return SizeW'(DepthDefault);
    return v;
  endfunction

  function automatic void clear_ring();
    skip_count      += CountW'(held);
    held            = '0;
    wr_ptr          = '0;
    rd_ptr          = '0;
    read_count      = '0;
    overwrite_count = '0;
  endfunction

  function automatic void push_result(logic signed [SampleW-1:0] s, logic [CountW-1:0] ts,
                                      logic srv, logic lst, logic ovw);
    expected_results.push_back(result_t'{s, ts, srv, lst, ovw, overwrite_count, skip_count,
                                         held});
  endfunction

  function automatic void predict_results(command_t c);
    logic signed [SampleW-1:0] vals [MaxBlockDefault];
    logic [CountW-1:0]         ts;
    logic                      ovw;
    case (c.cmd)
      CMD_ADD: begin
        // A held sample sitting at the write slot is lost to this add.
        ovw = (held != 0) && (rd_ptr == wr_ptr);
        ring_mem[wr_ptr[IdxW-1:0]] = c.sample;
        if (held < ring_size) held++;
        wr_ptr++;
        if (wr_ptr >= ring_size) wr_ptr = '0;
        if (ovw) begin
          rd_ptr = wr_ptr;
          overwrite_count++;
          skip_count++;
        end
        push_result('0, '0, 1'b0, 1'b1, ovw);
      end
      CMD_GET: begin
        ts = read_count;
        if (c.len == 0 || c.len > MaxBlockDefault || held < c.len) begin
          push_result('0, '0, 1'b0, 1'b1, 1'b0);
        end else begin
          for (int i = 0; i < c.len; i++) begin
            vals[i] = ring_mem[rd_ptr[IdxW-1:0]];
            rd_ptr++;
            if (rd_ptr >= ring_size) rd_ptr = '0;
            held--;
            read_count++;
          end
          // Every item of the block reports the fill level after the whole get.
          for (int i = 0; i < c.len; i++) begin
            push_result(vals[i], ts, 1'b1, (i + 1) == c.len, 1'b0);
          end
        end
      end
      CMD_RESET: begin
        clear_ring();
        push_result('0, '0, 1'b0, 1'b1, 1'b0);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic string show_result(result_t r);
    return $sformatf({"sample %0d ts %0d served %0b last %0b ovw %0b ",
                      "ovw_total %0d skip %0d fill %0d"},
                     r.sample, r.timestamp, r.served, r.last, r.overwrote, r.overwrite_total,
                     r.skipped_total, r.fill);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return '0;
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic queue_cmd(cmd_e c, logic signed [SampleW-1:0] s, logic [LenW-1:0] l);
    pending_cmds.push_back(command_t'{c, s, l});
    queued_count++;
  endtask

  // Idle means every command taken, every result seen and the block settled.
  task automatic wait_idle();
    while (accepted_count != queued_count || expected_results.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_size(logic [SizeW-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= SizeW'($urandom);
  endtask

  task automatic random_phase(logic [SizeW-1:0] size_cfg, int unsigned n_items);
    int unsigned eff;
    int unsigned made;
    int unsigned k;
    int unsigned roll;
    write_size(size_cfg);
    eff     = 32'(clamp_size(size_cfg));
    gaps_on = ($urandom_range(3) != 0);
    made    = 0;
    while (made < n_items) begin
      roll = $urandom_range(99);
      if (roll < 75) begin
        // A burst of adds and a get for part of it; bursts longer than the ring overwrite.
        k = $urandom_range(1, (eff < 10) ? eff + 3 : 10);
        repeat (k) queue_cmd(CMD_ADD, pick_sample(), LenW'($urandom));
        queue_cmd(CMD_GET, SampleW'($urandom), LenW'($urandom_range(1, (k < eff) ? k : eff)));
        made += k + 1;
      end else begin
        if (roll < 83) queue_cmd(CMD_GET, SampleW'($urandom), LenW'($urandom));
        else if (roll < 91) queue_cmd(CMD_RESET, SampleW'($urandom), LenW'($urandom));
        else if (roll < 96) queue_cmd(CMD_NONE, SampleW'($urandom), LenW'($urandom));
        else queue_cmd(CMD_ADD, pick_sample(), LenW'($urandom));
        made++;
      end
    end
  endtask

  // Driver: a new command goes out once the previous one has been transferred.
  always @(negedge clk) begin
    command_t c;
    if (rst_n && (!start || cmd_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        start        <= 1'b0;
        cmd          <= CmdW'($urandom);
        sample       <= SampleW'($urandom);
        block_length <= LenW'($urandom);
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        cmd          <= c.cmd;
        sample       <= c.sample;
        block_length <= c.len;
        start        <= 1'b1;
        gap_left     = gaps_on ? pick_gap() : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks strobed results, then predicts for the command taken at this edge.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      cmd_fire = start && !busy;
      if (strobe) begin
        got = result_t'{sample_out, timestamp, served, last, overwrote_now, overwrite_total,
                        skipped_total, fill_level};
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= MaxReports) $display("unexpected result: %s", show_result(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= MaxReports) begin
              $display("mismatch: expected %s", show_result(want));
              $display("          actual   %s", show_result(got));
            end
          end
        end
      end
      if (cmd_fire) begin
        predict_results(command_t'{cmd_e'(cmd), sample, block_length});
        accepted_count++;
      end
      if (cfg_valid && cfg_ready) begin
        ring_size = clamp_size(cfg_data);
        clear_ring();
      end
      if (cmd_fire || strobe || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Refusals on an empty ring and for bad lengths, extreme samples, served gets, a reset and an idle command.
    queue_cmd(CMD_GET, 16'h1234, 7'd1);
    queue_cmd(CMD_GET, 16'h0000, 7'd0);
    queue_cmd(CMD_ADD, 16'h7fff, 7'd127);
    queue_cmd(CMD_ADD, 16'h8000, 7'd0);
    queue_cmd(CMD_ADD, 16'h0000, 7'd64);
    queue_cmd(CMD_ADD, 16'hffff, 7'd65);
    queue_cmd(CMD_ADD, 16'h5555, 7'd1);
    queue_cmd(CMD_GET, 16'hffff, 7'd65);
    queue_cmd(CMD_GET, 16'h0000, 7'd127);
    queue_cmd(CMD_GET, 16'h0000, 7'd6);
    queue_cmd(CMD_GET, 16'h0000, 7'd2);
    queue_cmd(CMD_GET, 16'h0000, 7'd3);
    queue_cmd(CMD_ADD, 16'h0001, 7'd0);
    queue_cmd(CMD_ADD, 16'haaaa, 7'd0);
    queue_cmd(CMD_RESET, 16'h0000, 7'd0);
    queue_cmd(CMD_NONE, 16'hffff, 7'd127);
    queue_cmd(CMD_GET, 16'h0000, 7'd1);

    // A size of zero acts as one slot, so every add after the first overwrites.
    write_size(13'd0);
    queue_cmd(CMD_ADD, 16'sd100, 7'd0);
    queue_cmd(CMD_ADD, 16'sd200, 7'd0);
    queue_cmd(CMD_ADD, 16'sd300, 7'd0);
    queue_cmd(CMD_GET, 16'h0000, 7'd1);
    queue_cmd(CMD_GET, 16'h0000, 7'd1);

    // Oversized write saturates to the full depth; one maximum block goes through.
    write_size(13'h1fff);
    gaps_on = 1'b0;
    repeat (MaxBlockDefault) queue_cmd(CMD_ADD, pick_sample(), LenW'($urandom));
    queue_cmd(CMD_GET, 16'h0000, 7'd64);
    queue_cmd(CMD_GET, 16'h0000, 7'd64);

    random_phase(13'd2, 4);
    random_phase(13'd3, 4);
    random_phase(13'd5, 4);
    random_phase(13'd4097, 4);
    random_phase(13'd64, 4);
    random_phase(13'd1, 4);
    random_phase(SizeW'($urandom_range(6, 200)), 4);
    random_phase(13'd4096, 4);

    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
